>>> hdl/echo_distance_setpoint_comparator_macros.svh
// Assertion macros for the comparator RTL.
`ifndef ECHO_DISTANCE_SETPOINT_COMPARATOR_MACROS_SVH
`define ECHO_DISTANCE_SETPOINT_COMPARATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication under an active-low reset.
`define EDSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("edsc assertion failed");
// Next-cycle implication under an active-low reset.
`define EDSC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("edsc assertion failed");
`else
`define EDSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define EDSC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

>>> hdl/edsc_pkg.sv
package edsc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ECHO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ECHO = 2'd1;

    localparam logic [15:0] MIN_ECHO_RESET = 16'd100;
    localparam logic [15:0] MAX_ECHO_RESET = 16'd25000;
    localparam logic [7:0]  SETPOINT_RESET = 8'd50;

    // ticks / 58 as (ticks * 18079) >> 20, exact for all 16-bit ticks
    localparam logic [14:0] RECIP_M     = 15'd18079;
    localparam int          RECIP_SHIFT = 20;
    // 255 * 58: at or above this the distance saturates
    localparam logic [15:0] SAT_TICKS   = 16'd14790;
    localparam logic [7:0]  SAT_LIMIT   = 8'd255;

    localparam logic [7:0] RX_OFFSET  = 8'd128;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Digit count value at which the next digit closes an entry
    localparam logic [1:0] LAST_DIGIT = 2'd2;

    typedef struct packed {
        logic [15:0] echo_ticks;
        logic        byte_valid;
        logic [7:0]  rx_byte;
    } round_t;

    typedef struct packed {
        logic       in_range;
        logic [7:0] distance_cm;
        logic [7:0] setpoint_cm;
        logic       drive_back;
        logic       drive_forward;
        logic       echo_valid;
        logic [5:0] echo_char;
        logic       entry_done;
        logic       entry_invalid;
    } result_t;

    typedef struct packed {
        logic [7:0] setpoint;
        logic [1:0] digit_count;
        logic       drive_back;
        logic       drive_forward;
    } ctrl_state_t;

    typedef struct packed {
        logic       en;
        logic       idx;
        logic [3:0] digit;
    } digit_wr_t;

endpackage

>>> hdl/edsc_round.sv
module edsc_round
    import edsc_pkg::*;
(
    input  round_t      item,
    input  logic [15:0] min_echo_ticks,
    input  logic [15:0] max_echo_ticks,
    input  ctrl_state_t state,
    input  logic [3:0]  digit0,
    input  logic [3:0]  digit1,
    output ctrl_state_t state_next,
    output digit_wr_t   digit_wr,
    output result_t     result
);

    logic        range_ok;
    logic [30:0] prod;
    logic [7:0]  dist_cm;
    logic [7:0]  chr;
    logic        is_digit;
    logic        take;
    logic [3:0]  digit;
    logic [9:0]  entry_val;
    logic        done;
    logic        inval;

    always_comb
    begin
        range_ok = (item.echo_ticks > min_echo_ticks) && (item.echo_ticks < max_echo_ticks);
        prod     = 31'(item.echo_ticks) * 31'(RECIP_M);
        if (!range_ok)
            dist_cm = 8'd0;
        else if (item.echo_ticks >= SAT_TICKS)
            dist_cm = SAT_LIMIT;
        else
            dist_cm = prod[RECIP_SHIFT +: 8];

        chr      = item.rx_byte - RX_OFFSET;
        is_digit = chr inside {[ASCII_ZERO:ASCII_NINE]};
        take     = range_ok && item.byte_valid && is_digit;
        digit    = 4'(chr - ASCII_ZERO);

        entry_val = 10'(digit0) * 10'd100 + 10'(digit1) * 10'd10 + 10'(digit);
        done      = take && (state.digit_count == LAST_DIGIT);
        inval     = done && (entry_val >= 10'(SAT_LIMIT));

        state_next = state;
        if (take)
            state_next.digit_count = done ? 2'd0 : state.digit_count + 2'd1;
        if (done && !inval)
            state_next.setpoint = entry_val[7:0];
        if (range_ok)
        begin
            state_next.drive_back    = dist_cm > state_next.setpoint;
            state_next.drive_forward = dist_cm < state_next.setpoint;
        end

        // Third digit is used directly and never stored
        digit_wr.en    = take && !done;
        digit_wr.idx   = state.digit_count[0];
        digit_wr.digit = digit;

        result.in_range      = range_ok;
        result.distance_cm   = dist_cm;
        result.setpoint_cm   = state_next.setpoint;
        result.drive_back    = state_next.drive_back;
        result.drive_forward = state_next.drive_forward;
        result.echo_valid    = take;
        result.echo_char     = take ? chr[5:0] : 6'd0;
        result.entry_done    = done;
        result.entry_invalid = inval;
    end

endmodule

>>> hdl/echo_distance_setpoint_comparator.sv
// Echo distance setpoint comparator.
//
// Round channel (round_valid / round_stall / round_item): one item per
// measurement round carrying the echo length in ticks and an optional serial
// byte. Result channel (result_valid / result_stall / result_item): exactly
// one result item per round item, in order.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the lower echo limit, index 1 the upper one; other indexes are ignored.
// cfg_ready is always high. Write only while no round is in flight.
//
// An accepted item passes through the input register and then the result
// register. Throughput: one item per cycle while the receiver does not stall,
// set by the single pass through the input register, the 16x15 reciprocal
// multiply and the setpoint compare ahead of the result register.
// When the receiver stalls, the result holds; one more item still enters the
// input register, after which round_stall rises until the result is taken.
// Reset: limits 100/25000, setpoint 50, digit count 0, both drive lines off,
// pipeline empty.
`include "echo_distance_setpoint_comparator_macros.svh"

module echo_distance_setpoint_comparator
    import edsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   round_valid,
    output logic                   round_stall,
    input  round_t                 round_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    logic        s1_valid_reg;
    round_t      s1_item_reg;
    logic        out_valid_reg;
    result_t     out_item_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [15:0] min_echo_reg;
    logic [15:0] max_echo_reg;
    logic [3:0]  digit_store_reg [2];
    digit_wr_t   digit_wr;
    result_t     round_result;
    logic        out_free;
    logic        advance;
    logic        accept;

    // Output slot frees when empty or being taken this cycle
    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = s1_valid_reg && out_free;
    assign round_stall = s1_valid_reg && !out_free;
    assign accept      = round_valid && !round_stall;
    assign cfg_ready   = 1'b1;

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    edsc_round u_round (
        .item           (s1_item_reg),
        .min_echo_ticks (min_echo_reg),
        .max_echo_ticks (max_echo_reg),
        .state          (state_reg),
        .digit0         (digit_store_reg[0]),
        .digit1         (digit_store_reg[1]),
        .state_next     (state_next),
        .digit_wr       (digit_wr),
        .result         (round_result)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_echo_reg <= MIN_ECHO_RESET;
            max_echo_reg <= MAX_ECHO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_ECHO: min_echo_reg <= cfg_data;
                CFG_MAX_ECHO: max_echo_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Input register: load on accept, drain when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= round_item;
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= round_result;
    end

    // Control state commits exactly once per item, as it leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.setpoint      <= SETPOINT_RESET;
            state_reg.digit_count   <= 2'd0;
            state_reg.drive_back    <= 1'b0;
            state_reg.drive_forward <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Digit store holds the first two digits of an entry; no reset
    always_ff @(posedge clk)
    begin
        if (advance && digit_wr.en)
            digit_store_reg[digit_wr.idx] <= digit_wr.digit;
    end

    `EDSC_ASSERT_IMP(a_drive_exclusive, clk, rst_n, out_valid_reg,
        !(out_item_reg.drive_back && out_item_reg.drive_forward))
    `EDSC_ASSERT_IMP(a_invalid_needs_done, clk, rst_n,
        out_valid_reg && out_item_reg.entry_invalid, out_item_reg.entry_done)
    `EDSC_ASSERT_IMP(a_setpoint_below_sat, clk, rst_n, 1'b1,
        state_reg.setpoint != SAT_LIMIT)
    `EDSC_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, state_reg.digit_count != 2'd3)
    `EDSC_ASSERT_NXT(a_item_reaches_output, clk, rst_n, s1_valid_reg && out_free,
        out_valid_reg && (out_item_reg.setpoint_cm == state_reg.setpoint))

endmodule
